>>> rtl/apcs_pkg.sv
// Shared constants and state types for the area-proportional cell scatter.
package apcs_pkg;

  localparam int COUNT_W   = 31;
  localparam int DIM_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int AREA_W    = 2 * DIM_W;
  localparam int PROD_W    = COUNT_W + AREA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_W     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd5;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_CLAMP,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GEN,
    BK_START,
    BK_DIV,
    BK_SUM,
    BK_LEFT,
    BK_EMIT
  } back_state_t;

endpackage

>>> rtl/apcs_udiv.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module apcs_udiv #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] r;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {r, q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, d});
  assign quot  = q;
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      r <= '0;
      d <= den;
    end else if (busy) begin
      q <= {q[NUM_W-2:0], ge};
      r <= ge ? DEN_W'(trial - {1'b0, d}) : trial[DEN_W-1:0];
    end
  end

endmodule

>>> rtl/apcs_queue.sv
// Two-entry job queue between the classifier and the apportionment engine.
module apcs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] data_out,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= data_in;
    end
  end

endmodule

>>> rtl/apcs_front.sv
// Front end: accepts items, finds the clamped bin ranges by floor division, queues jobs.
module apcs_front #(
  parameter int CW = 32,
  parameter int M  = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [apcs_pkg::COUNT_W-1:0]       cell_count,
  input  logic signed [CW-1:0]               rect_x_low,
  input  logic signed [CW-1:0]               rect_y_low,
  input  logic signed [CW-1:0]               rect_x_high,
  input  logic signed [CW-1:0]               rect_y_high,
  input  logic signed [CW-1:0]               origin_x,
  input  logic signed [CW-1:0]               origin_y,
  input  logic [apcs_pkg::DIM_W-1:0]         bin_w,
  input  logic [apcs_pkg::DIM_W-1:0]         bin_h,
  input  logic [apcs_pkg::DIM_W-1:0]         cols,
  input  logic [apcs_pkg::DIM_W-1:0]         rows,
  output logic                               job_push,
  input  logic                               job_full,
  output logic [apcs_pkg::COUNT_W+4*CW+4*apcs_pkg::DIM_W-1:0] job_data
);

  localparam int DW = apcs_pkg::DIM_W;
  localparam int QW = CW + 2;
  localparam logic signed [QW-1:0] SPAN = QW'(M - 1);

  apcs_pkg::front_state_t state, state_next;

  logic [apcs_pkg::COUNT_W-1:0] v;
  logic signed [CW-1:0] xl, yl, xh, yh;

  // divider lanes: 0 x low, 1 x high, 2 y low, 3 y high
  logic signed [CW:0] diff [4];
  logic [CW-1:0]      num  [4];
  logic [CW-1:0]      quot [4];
  logic [3:0]         neg;
  logic [3:0]         busy;
  logic               div_start;
  logic               accept;

  logic signed [QW-1:0] q [4];
  logic signed [QW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [QW-1:0] cols_m1, rows_m1;
  logic signed [QW-1:0] hi_x_cap, hi_y_cap;
  logic                 range_empty;

  function automatic logic [CW:0] xl_in_ext(input logic [CW-1:0] a);
    xl_in_ext = {a[CW-1], a};
  endfunction

  assign accept = in_valid && !in_stall;

  assign diff[0] = {xl_in_ext(rect_x_low)} - {origin_x[CW-1], origin_x};
  assign diff[1] = {xl_in_ext(rect_x_high)} - {origin_x[CW-1], origin_x} - 1'b1;
  assign diff[2] = {xl_in_ext(rect_y_low)} - {origin_y[CW-1], origin_y};
  assign diff[3] = {xl_in_ext(rect_y_high)} - {origin_y[CW-1], origin_y} - 1'b1;

  // floor(a/b) for negative a is ~(~a / b)
  for (genvar g = 0; g < 4; g++) begin : g_div
    assign num[g] = diff[g][CW] ? ~diff[g][CW-1:0] : diff[g][CW-1:0];
    apcs_udiv #(.NUM_W(CW), .DEN_W(DW)) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (num[g]),
      .den   ((g < 2) ? bin_w : bin_h),
      .busy  (busy[g]),
      .quot  (quot[g]),
      .rem   ()
    );
    assign q[g] = neg[g] ? ~{2'b00, quot[g]} : {2'b00, quot[g]};
  end

  assign cols_m1 = {{(QW-DW){1'b0}}, cols} - 1'b1;
  assign rows_m1 = {{(QW-DW){1'b0}}, rows} - 1'b1;

  assign range_empty = (lo_x > hi_x) || (lo_y > hi_y);
  assign hi_x_cap    = (hi_x > lo_x + SPAN) ? lo_x + SPAN : hi_x;
  assign hi_y_cap    = (hi_y > lo_y + SPAN) ? lo_y + SPAN : hi_y;

  assign job_data = {v, xl, yl, xh, yh,
                     lo_y[DW-1:0], hi_y_cap[DW-1:0],
                     lo_x[DW-1:0], hi_x_cap[DW-1:0]};

  always_comb begin
    state_next = state;
    case (state)
      apcs_pkg::FR_IDLE:  if (div_start) state_next = apcs_pkg::FR_DIV;
      apcs_pkg::FR_DIV:   if (busy == 4'b0000) state_next = apcs_pkg::FR_CLAMP;
      apcs_pkg::FR_CLAMP: state_next = apcs_pkg::FR_PUSH;
      apcs_pkg::FR_PUSH:  if (range_empty || !job_full) state_next = apcs_pkg::FR_IDLE;
      default:            state_next = apcs_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != apcs_pkg::FR_IDLE);
    div_start = 1'b0;
    job_push  = 1'b0;
    case (state)
      apcs_pkg::FR_IDLE: begin
        // zero count or empty rectangle gives nothing: drop on the spot
        div_start = in_valid && (cell_count != '0) &&
                    (rect_x_low < rect_x_high) && (rect_y_low < rect_y_high);
      end
      apcs_pkg::FR_PUSH: begin
        job_push = !range_empty && !job_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apcs_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v   <= cell_count;
      xl  <= rect_x_low;
      yl  <= rect_y_low;
      xh  <= rect_x_high;
      yh  <= rect_y_high;
      neg <= {diff[3][CW], diff[2][CW], diff[1][CW], diff[0][CW]};
    end
    if (state == apcs_pkg::FR_CLAMP) begin
      lo_x <= (q[0] < 0) ? '0 : q[0];
      hi_x <= (q[1] > cols_m1) ? cols_m1 : q[1];
      lo_y <= (q[2] < 0) ? '0 : q[2];
      hi_y <= (q[3] > rows_m1) ? rows_m1 : q[3];
    end
  end

endmodule

>>> rtl/apcs_back.sv
// Back end: walks the overlapped bins, divides the shares and hands out the leftover.
module apcs_back #(
  parameter int CW = 32,
  parameter int M  = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               job_empty,
  output logic                               job_pop,
  input  logic [apcs_pkg::COUNT_W+4*CW+4*apcs_pkg::DIM_W-1:0] job_data,
  input  logic signed [CW-1:0]               origin_x,
  input  logic signed [CW-1:0]               origin_y,
  input  logic [apcs_pkg::DIM_W-1:0]         bin_w,
  input  logic [apcs_pkg::DIM_W-1:0]         bin_h,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [apcs_pkg::DIM_W-1:0]         bin_row,
  output logic [apcs_pkg::DIM_W-1:0]         bin_col,
  output logic [apcs_pkg::COUNT_W-1:0]       amount,
  output logic                               last
);

  localparam int DW     = apcs_pkg::DIM_W;
  localparam int VW     = apcs_pkg::COUNT_W;
  localparam int AW     = apcs_pkg::AREA_W;
  localparam int PW     = apcs_pkg::PROD_W;
  localparam int GW     = ((CW > AW + 1) ? CW : AW + 1) + 2;
  localparam int IDX_W  = (M > 1) ? $clog2(M) : 1;
  localparam int RK_W   = $clog2(M + 1);
  localparam int SW     = VW + $clog2(M) + 1;

  apcs_pkg::back_state_t state, state_next;

  logic [VW-1:0]        v;
  logic signed [CW-1:0] xl, yl, xh, yh;
  logic [DW-1:0]        rhi, clo, chi;
  logic [DW-1:0]        r, c;
  logic [IDX_W-1:0]     k, i, nlast;
  logic [2:0]           step;
  logic                 gen_done;

  logic [AW-1:0]        offx, offy;
  logic signed [GW-1:0] gx, gxe, gy, gye;
  logic signed [GW-1:0] lox, hix, loy, hiy;
  logic [DW-1:0]        ovx, ovy;
  logic [AW-1:0]        ab;
  logic [AW-1:0]        area;

  logic [PW-1:0]        prod    [M];
  logic [DW-1:0]        row_of  [M];
  logic [DW-1:0]        col_of  [M];
  logic [PW-1:0]        quot    [M];
  logic [AW-1:0]        rem     [M];
  logic [M-1:0]         busy;
  logic                 div_start;

  logic [SW-1:0]        sum;
  logic [VW-1:0]        leftover;
  logic [RK_W-1:0]      rank;
  logic                 inc;
  logic                 out_free;
  logic                 out_load;

  function automatic logic signed [GW-1:0] sx(input logic [CW-1:0] a);
    sx = {{(GW-CW){a[CW-1]}}, a};
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign gen_done = (k == IDX_W'(M - 1)) || ((r == rhi) && (c == chi));

  for (genvar g = 0; g < M; g++) begin : g_div
    apcs_udiv #(.NUM_W(PW), .DEN_W(AW)) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (prod[g]),
      .den   (area),
      .busy  (busy[g]),
      .quot  (quot[g]),
      .rem   (rem[g])
    );
  end

  // largest remainder first, ties to the earlier bin in row-major order
  always_comb begin
    rank = '0;
    for (int j = 0; j < M; j++) begin
      if ((IDX_W'(j) <= nlast) &&
          ((rem[j] > rem[i]) || ((rem[j] == rem[i]) && (IDX_W'(j) < i)))) begin
        rank = rank + 1'b1;
      end
    end
  end

  assign inc = ({{(VW-RK_W){1'b0}}, rank} < leftover);

  always_comb begin
    state_next = state;
    case (state)
      apcs_pkg::BK_IDLE:  if (!job_empty) state_next = apcs_pkg::BK_GEN;
      apcs_pkg::BK_GEN:   if ((step == 3'd5) && gen_done) state_next = apcs_pkg::BK_START;
      apcs_pkg::BK_START: state_next = apcs_pkg::BK_DIV;
      apcs_pkg::BK_DIV:   if (busy == '0) state_next = apcs_pkg::BK_SUM;
      apcs_pkg::BK_SUM:   if (i == nlast) state_next = apcs_pkg::BK_LEFT;
      apcs_pkg::BK_LEFT:  state_next = apcs_pkg::BK_EMIT;
      apcs_pkg::BK_EMIT:  if (out_free && (i == nlast)) state_next = apcs_pkg::BK_IDLE;
      default:            state_next = apcs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      apcs_pkg::BK_IDLE:  job_pop   = !job_empty;
      apcs_pkg::BK_START: div_start = 1'b1;
      apcs_pkg::BK_EMIT:  out_load  = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= apcs_pkg::BK_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      k         <= '0;
      i         <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        apcs_pkg::BK_IDLE: begin
          step <= '0;
          k    <= '0;
        end
        apcs_pkg::BK_GEN: begin
          if (step == 3'd5) begin
            step <= '0;
            if (!gen_done) begin
              k <= k + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        apcs_pkg::BK_DIV: i <= '0;
        apcs_pkg::BK_SUM: if (i != nlast) i <= i + 1'b1;
        apcs_pkg::BK_LEFT: i <= '0;
        apcs_pkg::BK_EMIT: if (out_free && (i != nlast)) i <= i + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    area <= bin_w * bin_h;
    if (job_pop) begin
      // the walk starts at the lowest row of the job
      {v, xl, yl, xh, yh, r, rhi, clo, chi} <= job_data;
      c <= job_data[DW +: DW];
    end
    if (state == apcs_pkg::BK_GEN) begin
      case (step)
        3'd0: begin
          offx <= c * bin_w;
          offy <= r * bin_h;
        end
        3'd1: begin
          gx  <= sx(origin_x) + {{(GW-AW){1'b0}}, offx};
          gxe <= sx(origin_x) + {{(GW-AW){1'b0}}, offx} + {{(GW-DW){1'b0}}, bin_w};
          gy  <= sx(origin_y) + {{(GW-AW){1'b0}}, offy};
          gye <= sx(origin_y) + {{(GW-AW){1'b0}}, offy} + {{(GW-DW){1'b0}}, bin_h};
        end
        3'd2: begin
          lox <= (sx(xl) > gx) ? sx(xl) : gx;
          hix <= (sx(xh) < gxe) ? sx(xh) : gxe;
          loy <= (sx(yl) > gy) ? sx(yl) : gy;
          hiy <= (sx(yh) < gye) ? sx(yh) : gye;
        end
        3'd3: begin
          ovx <= DW'(hix - lox);
          ovy <= DW'(hiy - loy);
        end
        3'd4: ab <= ovx * ovy;
        3'd5: begin
          prod[k]   <= v * ab;
          row_of[k] <= r;
          col_of[k] <= c;
          nlast     <= k;
          if (c == chi) begin
            c <= clo;
            r <= r + 1'b1;
          end else begin
            c <= c + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (state == apcs_pkg::BK_DIV) begin
      sum <= '0;
    end else if (state == apcs_pkg::BK_SUM) begin
      sum <= sum + {{(SW-VW){1'b0}}, quot[i][VW-1:0]};
    end
    if (state == apcs_pkg::BK_LEFT) begin
      leftover <= (sum < {{(SW-VW){1'b0}}, v}) ? VW'({{(SW-VW){1'b0}}, v} - sum) : '0;
    end
    if (out_load) begin
      bin_row <= row_of[i];
      bin_col <= col_of[i];
      amount  <= quot[i][VW-1:0] + {{(VW-1){1'b0}}, inc};
      last    <= (i == nlast);
    end
  end

endmodule

>>> rtl/area_proportional_cell_scatter.sv
// Top level of the area-proportional cell scatter: configuration registers and front/queue/back.
// Each accepted transaction spreads cell_count over the up to MAX_OVERLAP_BINS grid bins that the
// half-open rectangle overlaps, giving floor(count*overlap/bin_area) to each bin and the leftover
// units to the largest remainders (ties to lower row, then lower column); one result transaction
// per bin in row-major order, with last on the final one. The front end takes an item, runs four
// floor dividers in parallel to find the bin range and queues a job; it takes no new item until
// the last one is queued or dropped. A zero count or an empty rectangle is dropped in the cycle
// it arrives. The back end picks up a job, forms the product of each bin in turn (offset, edges,
// clipped overlap, area, count times area), starts and runs the 63-by-32-bit share dividers (one
// per bin, all running together), sums the shares, finds the leftover and emits one result per
// bin, and takes the next job only after the last result of this one. A two-entry job queue
// lets the front work on the next item while the back end is busy. Configuration writes are
// always ready.
module area_proportional_cell_scatter #(
  parameter int MAX_OVERLAP_BINS = 4,
  parameter int COORD_BITS       = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [apcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]              cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [apcs_pkg::COUNT_W-1:0]       cell_count,
  input  logic signed [COORD_BITS-1:0]       rect_x_low,
  input  logic signed [COORD_BITS-1:0]       rect_y_low,
  input  logic signed [COORD_BITS-1:0]       rect_x_high,
  input  logic signed [COORD_BITS-1:0]       rect_y_high,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [apcs_pkg::DIM_W-1:0]         bin_row,
  output logic [apcs_pkg::DIM_W-1:0]         bin_col,
  output logic [apcs_pkg::COUNT_W-1:0]       amount,
  output logic                               last
);

  localparam int DW    = apcs_pkg::DIM_W;
  localparam int JOB_W = apcs_pkg::COUNT_W + 4 * COORD_BITS + 4 * DW;

  logic signed [COORD_BITS-1:0] grid_origin_x;
  logic signed [COORD_BITS-1:0] grid_origin_y;
  logic [DW-1:0] bin_width, bin_height, grid_cols, grid_rows;
  logic [DW-1:0] bw_eff, bh_eff;

  logic             job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0] job_in, job_out;

  assign cfg_ready = 1'b1;

  // a zero bin size behaves as one
  assign bw_eff = (bin_width == '0) ? DW'(1) : bin_width;
  assign bh_eff = (bin_height == '0) ? DW'(1) : bin_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_origin_x <= '0;
      grid_origin_y <= '0;
      bin_width     <= DW'(1);
      bin_height    <= DW'(1);
      grid_cols     <= DW'(1);
      grid_rows     <= DW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        apcs_pkg::CFG_ORIGIN_X:  grid_origin_x <= cfg_data;
        apcs_pkg::CFG_ORIGIN_Y:  grid_origin_y <= cfg_data;
        apcs_pkg::CFG_BIN_W:     bin_width     <= cfg_data[DW-1:0];
        apcs_pkg::CFG_BIN_H:     bin_height    <= cfg_data[DW-1:0];
        apcs_pkg::CFG_GRID_COLS: grid_cols     <= cfg_data[DW-1:0];
        apcs_pkg::CFG_GRID_ROWS: grid_rows     <= cfg_data[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  apcs_front #(.CW(COORD_BITS), .M(MAX_OVERLAP_BINS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cell_count  (cell_count),
    .rect_x_low  (rect_x_low),
    .rect_y_low  (rect_y_low),
    .rect_x_high (rect_x_high),
    .rect_y_high (rect_y_high),
    .origin_x    (grid_origin_x),
    .origin_y    (grid_origin_y),
    .bin_w       (bw_eff),
    .bin_h       (bh_eff),
    .cols        (grid_cols),
    .rows        (grid_rows),
    .job_push    (job_push),
    .job_full    (job_full),
    .job_data    (job_in)
  );

  apcs_queue #(.WIDTH(JOB_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .data_in  (job_in),
    .full     (job_full),
    .pop      (job_pop),
    .data_out (job_out),
    .empty    (job_empty)
  );

  apcs_back #(.CW(COORD_BITS), .M(MAX_OVERLAP_BINS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job_data  (job_out),
    .origin_x  (grid_origin_x),
    .origin_y  (grid_origin_y),
    .bin_w     (bw_eff),
    .bin_h     (bh_eff),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bin_row   (bin_row),
    .bin_col   (bin_col),
    .amount    (amount),
    .last      (last)
  );

endmodule

>>> sim/testbench.sv
// Testbench for area_proportional_cell_scatter: directed and random transactions against a scoreboard.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_BINS  = 4;
  localparam int CW        = 32;
  localparam int DIM_W     = apcs_pkg::DIM_W;
  localparam int COUNT_W   = apcs_pkg::COUNT_W;
  localparam int CFG_IDX_W = apcs_pkg::CFG_IDX_W;

  typedef struct packed {
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [COUNT_W-1:0] amt;
    logic               lst;
  } bin_share_t;

  class share_scoreboard;
    bin_share_t pending[$];
    int         errors;
    longint     org_x, org_y, bin_w, bin_h, cols, rows;

    function new();
      errors = 0;
      org_x = 0; org_y = 0; bin_w = 1; bin_h = 1; cols = 1; rows = 1;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
      case (idx)
        apcs_pkg::CFG_ORIGIN_X:  org_x = longint'(signed'(data));
        apcs_pkg::CFG_ORIGIN_Y:  org_y = longint'(signed'(data));
        apcs_pkg::CFG_BIN_W:     bin_w = data[15:0];
        apcs_pkg::CFG_BIN_H:     bin_h = data[15:0];
        apcs_pkg::CFG_GRID_COLS: cols = data[15:0];
        apcs_pkg::CFG_GRID_ROWS: rows = data[15:0];
        default: ;
      endcase
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if (a % b != 0 && a < 0) q = q - 1;
      return q;
    endfunction

    function longint lmin(longint a, longint b);
      return a < b ? a : b;
    endfunction

    function longint lmax(longint a, longint b);
      return a > b ? a : b;
    endfunction

    // accepted input transaction -> expected bin shares
    function void note_item(logic [COUNT_W-1:0] cnt, logic [CW-1:0] xlr, logic [CW-1:0] ylr,
                            logic [CW-1:0] xhr, logic [CW-1:0] yhr);
      longint v, xl, yl, xh, yh, bw, bh, area, clo, chi, rlo, rhi, gx, gy, ox, oy, prod;
      longint bsum, left, rank;
      longint e_row[MAX_BINS], e_col[MAX_BINS], e_base[MAX_BINS], e_rem[MAX_BINS];
      int n;
      bin_share_t s;
      v = cnt;
      xl = longint'(signed'(xlr)); yl = longint'(signed'(ylr));
      xh = longint'(signed'(xhr)); yh = longint'(signed'(yhr));
      bw = bin_w ? bin_w : 1;
      bh = bin_h ? bin_h : 1;
      area = bw * bh;
      n = 0;
      bsum = 0;
      if (v == 0) return;
      clo = lmax(0, fdiv(xl - org_x, bw));
      chi = lmin(cols - 1, fdiv(xh - 1 - org_x, bw));
      rlo = lmax(0, fdiv(yl - org_y, bh));
      rhi = lmin(rows - 1, fdiv(yh - 1 - org_y, bh));
      if (clo > chi || rlo > rhi) return;
      rhi = lmin(rhi, rlo + MAX_BINS - 1);
      chi = lmin(chi, clo + MAX_BINS - 1);
      for (longint r = rlo; r <= rhi && n < MAX_BINS; r++) begin
        for (longint c = clo; c <= chi && n < MAX_BINS; c++) begin
          gx = org_x + c * bw;
          gy = org_y + r * bh;
          ox = lmin(xh, gx + bw) - lmax(xl, gx);
          oy = lmin(yh, gy + bh) - lmax(yl, gy);
          if (ox > 0 && oy > 0) begin
            prod = v * (ox * oy);
            e_row[n] = r;
            e_col[n] = c;
            e_base[n] = prod / area;
            e_rem[n] = prod % area;
            bsum += e_base[n];
            n++;
          end
        end
      end
      left = (bsum < v) ? v - bsum : 0;
      for (int i = 0; i < n; i++) begin
        rank = 0;
        for (int j = 0; j < n; j++)
          if (e_rem[j] > e_rem[i] || (e_rem[j] == e_rem[i] && j < i)) rank++;
        s.row = e_row[i][15:0];
        s.col = e_col[i][15:0];
        s.amt = COUNT_W'(e_base[i] + ((rank < left) ? 1 : 0));
        s.lst = (i == n - 1);
        pending = {pending, s};
      end
    endfunction

    task check_share(bin_share_t got);
      bin_share_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d amount %0d",
                         got.row, got.col, got.amt));
      end else begin
        want = pending.pop_front();
        if (got.row !== want.row)
          report($sformatf("bin_row %0d, expected %0d", got.row, want.row));
        if (got.col !== want.col)
          report($sformatf("bin_col %0d, expected %0d", got.col, want.col));
        if (got.amt !== want.amt)
          report($sformatf("amount %0d, expected %0d", got.amt, want.amt));
        if (got.lst !== want.lst)
          report($sformatf("last %0b, expected %0b", got.lst, want.lst));
      end
    endtask
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [COUNT_W-1:0] cell_count;
  logic signed [CW-1:0] rect_x_low, rect_y_low, rect_x_high, rect_y_high;
  logic out_valid, out_stall;
  logic [DIM_W-1:0] bin_row, bin_col;
  logic [COUNT_W-1:0] amount;
  logic last;

  share_scoreboard sb;
  int send_idle_pct, recv_stall_pct;

  area_proportional_cell_scatter #(.MAX_OVERLAP_BINS(MAX_BINS), .COORD_BITS(CW)) i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .cell_count, .rect_x_low, .rect_y_low, .rect_x_high, .rect_y_high,
    .out_valid, .out_stall, .bin_row, .bin_col, .amount, .last
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_share({bin_row, bin_col, amount, last});
  end

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // 16-bit registers get random upper bits; the block ignores them
  task set_grid(longint ox, longint oy, int bw, int bh, int nc, int nr);
    cfg_write(apcs_pkg::CFG_ORIGIN_X, ox[31:0]);
    cfg_write(apcs_pkg::CFG_ORIGIN_Y, oy[31:0]);
    cfg_write(apcs_pkg::CFG_BIN_W, {16'($urandom), 16'(bw)});
    cfg_write(apcs_pkg::CFG_BIN_H, {16'($urandom), 16'(bh)});
    cfg_write(apcs_pkg::CFG_GRID_COLS, {16'($urandom), 16'(nc)});
    cfg_write(apcs_pkg::CFG_GRID_ROWS, {16'($urandom), 16'(nr)});
    cfg_write(3'($urandom_range(6, 7)), $urandom);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task send(logic [COUNT_W-1:0] cnt, longint xl, longint yl, longint xh, longint yh);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cell_count = cnt;
    rect_x_low = xl[31:0];
    rect_y_low = yl[31:0];
    rect_x_high = xh[31:0];
    rect_y_high = yh[31:0];
    do @(posedge clk); while (in_stall);
    sb.note_item(cnt, xl[31:0], yl[31:0], xh[31:0], yh[31:0]);
  endtask

  // idle input, then wait out all results plus the cycles of items that yield none
  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function logic [COUNT_W-1:0] rand_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return COUNT_W'($urandom_range(1, 9));
      4, 5: return COUNT_W'($urandom_range(1, 1000));
      default: return COUNT_W'($urandom);
    endcase
  endfunction

  task rand_item();
    longint bw, bh, c, r, xl, yl;
    bw = sb.bin_w ? sb.bin_w : 1;
    bh = sb.bin_h ? sb.bin_h : 1;
    if ($urandom_range(0, 9) == 0) begin
      send(COUNT_W'($urandom), $urandom, $urandom, $urandom, $urandom);
    end else begin
      c = longint'($urandom_range(0, (sb.cols > 8 ? 8 : sb.cols) + 1)) - 1;
      r = longint'($urandom_range(0, (sb.rows > 8 ? 8 : sb.rows) + 1)) - 1;
      if ($urandom_range(0, 3) == 0) c = sb.cols - longint'($urandom_range(0, 1));
      xl = sb.org_x + c * bw + longint'($urandom_range(0, 2 * bw)) - bw;
      yl = sb.org_y + r * bh + longint'($urandom_range(0, 2 * bh)) - bh;
      send(rand_count(), xl, yl, xl + $urandom_range(0, bw), yl + $urandom_range(0, bh));
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; cell_count = '0;
    rect_x_low = '0; rect_y_low = '0; rect_x_high = '0; rect_y_high = '0;
    out_stall = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset grid: single 1x1 bin at the origin
    send(5, 0, 0, 1, 1);
    send(5, 0, 0, 2, 2);
    drain();

    set_grid(0, 0, 4, 4, 3, 3);
    send(0, 1, 1, 5, 5);                         // zero count
    send('1, 2, 2, 6, 6);                        // max count over 2x2
    send(7, 1, 1, 5, 5);                         // equal remainders
    send(10, 3, 3, 3, 7);                        // empty rectangle
    send(10, -8, -8, -4, -4);                    // off grid
    send(10, 4, 0, 8, 4);                        // edge contact with neighbors
    send(10, -2, -2, 2, 2);                      // clipped at origin
    send(9, 10, 10, 14, 14);                     // clipped at far corner
    send(100, 0, 0, 12, 12);                     // larger than a bin
    send('1, 0, 0, 12, 12);                      // base shares exceed count
    send(3, 3, 1, 6, 2);                         // unequal remainders
    send('1, -2147483648, -2147483648, 2147483647, 2147483647);
    send(1, 2147483647, 2147483647, -2147483648, -2147483648);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_grid(-2147483648, -2147483648, 65535, 65535, 65535, 65535);
        1: set_grid(2147483647, 2147483647, 1, 1, 65535, 65535);
        2: set_grid(5, -3, 0, 0, 4, 4);          // zero bin size acts as one
        3: set_grid(0, 0, 3, 5, 0, 0);           // zero grid size
        4: set_grid(-100, 40, 65535, 7, 3, 2);
        default: set_grid($urandom_range(0, 1) ? $signed($urandom) :
                          longint'($urandom_range(0, 100)) - 50,
                          longint'($urandom_range(0, 100)) - 50,
                          $urandom_range(1, 20), $urandom_range(1, 20),
                          $urandom_range(1, 6), $urandom_range(1, 6));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int k = 0; k < 32; k++) begin
        if (ph == 5 && k == 16) begin
          @(negedge clk);
          in_valid = 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
        rand_item();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/apcs_pkg.sv
rtl/apcs_udiv.sv
rtl/apcs_queue.sv
rtl/apcs_front.sv
rtl/apcs_back.sv
rtl/area_proportional_cell_scatter.sv
sim/testbench.sv
